/* rtl/core/jmhp_pkg.sv */
// jmhp_pkg: types and constants for the jpeg marker header parser
// phase codes, result kinds, marker codes and the result item struct
// no dependencies

package jmhp_pkg;

  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] MARKER_LOW   = 8'hC0;
  localparam logic [7:0] MARKER_HIGH  = 8'hFE;
  localparam logic [7:0] MARKER_SOF0  = 8'hC0;
  localparam logic [7:0] MARKER_DQT   = 8'hDB;
  localparam logic [7:0] MARKER_DRI   = 8'hDD;
  localparam logic [7:0] MARKER_SOS   = 8'hDA;
  localparam logic [7:0] MARKER_EOI   = 8'hD9;

  localparam logic [3:0] DQT_SKIP_LEN = 4'd3;
  localparam logic [3:0] SOF_SKIP_LEN = 4'd3;
  localparam logic [3:0] SOS_SKIP_LEN = 4'd12;
  localparam logic [5:0] LAST_ENTRY   = 6'd63;

  typedef enum logic [2:0] {
    KIND_LUMA    = 3'd0,
    KIND_CHROMA  = 3'd1,
    KIND_HEADER  = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  typedef enum logic [12:0] {
    PH_SCAN     = 13'b0_0000_0000_0001,
    PH_DQT_SKIP = 13'b0_0000_0000_0010,
    PH_LUMA     = 13'b0_0000_0000_0100,
    PH_DQT_GAP  = 13'b0_0000_0000_1000,
    PH_CHROMA   = 13'b0_0000_0001_0000,
    PH_SOF_SKIP = 13'b0_0000_0010_0000,
    PH_H_HI     = 13'b0_0000_0100_0000,
    PH_H_LO     = 13'b0_0000_1000_0000,
    PH_W_HI     = 13'b0_0001_0000_0000,
    PH_W_LO     = 13'b0_0010_0000_0000,
    PH_SOS_SKIP = 13'b0_0100_0000_0000,
    PH_PAYLOAD  = 13'b0_1000_0000_0000,
    PH_SWALLOW  = 13'b1_0000_0000_0000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  table_index;
    logic [7:0]  byte_value;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        frame_type;
    logic        tables_seen;
    logic        restart_seen;
    logic        end_status;
    logic        last_of_frame;
  } item_t;

endpackage

/* rtl/core/jpeg_marker_header_parser_unit.sv */
// jpeg_marker_header_parser_unit: byte-serial jpeg marker segment parser
// decodes one frame byte per cycle while in_ready is high into table, header, payload and end items
// depends on jmhp_pkg

// Takes one frame byte per cycle and decodes it in one registered pass. Most
// bytes give zero or one result item; the frame's last byte, if it is a table
// entry, gives two (its own item plus an end item), the second held in a
// pending stage so input stalls until that item moves to the output. in_ready
// is high when the pending stage is empty and the output register is empty
// or transfers in the same cycle, so with out_ready held high the block
// sustains one byte per cycle, apart from that stall at such a frame end. A
// byte's own result is registered and appears in the cycle after its transfer.

module jpeg_marker_header_parser_unit
  import jmhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [5:0]  table_index,
  output logic [7:0]  byte_value,
  output logic [15:0] frame_width,
  output logic [15:0] frame_height,
  output logic        frame_type,
  output logic [7:0]  quality,
  output logic        restart_seen,
  output logic        end_status,
  output logic        last_of_frame
);

  phase_t      phase, phase_next;
  logic [3:0]  skip_count, skip_count_next;
  logic [5:0]  entry_index, entry_index_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        baseline_flag, baseline_flag_next;
  logic        tables_flag, tables_flag_next;
  logic        restart_flag, restart_flag_next;
  logic        prev_was_ff, prev_was_ff_next;

  item_t       out_item, pend_item;
  logic        pend_valid;

  logic        emit_valid;
  kind_t       emit_kind;
  logic [5:0]  emit_index;
  logic [7:0]  emit_value;
  logic        emit_status;
  logic        emit_last;
  logic        final_done;
  logic        end_valid;
  logic        skip_end;
  logic        is_marker;
  item_t       main_item, end_item;
  logic        accept, pop;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;
  assign in_ready = !pend_valid && (!out_valid || out_ready);

  assign skip_end  = (skip_count <= 4'd1);
  assign is_marker = prev_was_ff && (data_byte >= MARKER_LOW) && (data_byte <= MARKER_HIGH);

  always_comb begin
    phase_next         = phase;
    skip_count_next    = skip_count;
    entry_index_next   = entry_index;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    baseline_flag_next = baseline_flag;
    tables_flag_next   = tables_flag;
    restart_flag_next  = restart_flag;
    prev_was_ff_next   = prev_was_ff;
    emit_valid  = 1'b0;
    emit_kind   = KIND_END;
    emit_index  = 6'd0;
    emit_value  = 8'd0;
    emit_status = 1'b0;
    emit_last   = frame_last;
    final_done  = 1'b0;
    case (phase)
      PH_SCAN: begin
        if (is_marker) begin
          prev_was_ff_next = 1'b0;
          if (data_byte == MARKER_DQT) begin
            tables_flag_next = 1'b1;
            phase_next       = PH_DQT_SKIP;
            skip_count_next  = DQT_SKIP_LEN;
          end else if (data_byte == MARKER_SOF0) begin
            baseline_flag_next = 1'b1;
            phase_next         = PH_SOF_SKIP;
            skip_count_next    = SOF_SKIP_LEN;
          end else if (data_byte == MARKER_DRI) begin
            restart_flag_next = 1'b1;
          end else if (data_byte == MARKER_SOS) begin
            phase_next      = PH_SOS_SKIP;
            skip_count_next = SOS_SKIP_LEN;
          end else if (data_byte == MARKER_EOI) begin
            emit_valid = 1'b1;
            emit_kind  = KIND_END;
            final_done = 1'b1;
            phase_next = PH_SWALLOW;
          end
        end else begin
          prev_was_ff_next = (data_byte == BYTE_FF);
        end
      end
      PH_DQT_SKIP: begin
        skip_count_next = skip_end ? 4'd0 : skip_count - 4'd1;
        if (skip_end) begin
          phase_next       = PH_LUMA;
          entry_index_next = 6'd0;
        end
      end
      PH_LUMA: begin
        emit_valid       = 1'b1;
        emit_kind        = KIND_LUMA;
        emit_index       = entry_index;
        emit_value       = data_byte;
        emit_last        = 1'b0;
        entry_index_next = entry_index + 6'd1;
        if (entry_index == LAST_ENTRY) phase_next = PH_DQT_GAP;
      end
      PH_DQT_GAP: begin
        phase_next       = PH_CHROMA;
        entry_index_next = 6'd0;
      end
      PH_CHROMA: begin
        emit_valid       = 1'b1;
        emit_kind        = KIND_CHROMA;
        emit_index       = entry_index;
        emit_value       = data_byte;
        emit_last        = 1'b0;
        entry_index_next = entry_index + 6'd1;
        if (entry_index == LAST_ENTRY) phase_next = PH_SCAN;
      end
      PH_SOF_SKIP: begin
        skip_count_next = skip_end ? 4'd0 : skip_count - 4'd1;
        if (skip_end) phase_next = PH_H_HI;
      end
      PH_H_HI: begin
        height_reg_next = {data_byte, 8'd0};
        phase_next      = PH_H_LO;
      end
      PH_H_LO: begin
        height_reg_next = {height_reg[15:8], data_byte};
        phase_next      = PH_W_HI;
      end
      PH_W_HI: begin
        width_reg_next = {data_byte, 8'd0};
        phase_next     = PH_W_LO;
      end
      PH_W_LO: begin
        width_reg_next = {width_reg[15:8], data_byte};
        phase_next     = PH_SCAN;
      end
      PH_SOS_SKIP: begin
        skip_count_next = skip_end ? 4'd0 : skip_count - 4'd1;
        // a frame ending mid-skip still gets its scan header
        if (skip_end || frame_last) begin
          emit_valid = 1'b1;
          emit_kind  = KIND_HEADER;
          final_done = frame_last;
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit_valid = 1'b1;
        emit_kind  = KIND_PAYLOAD;
        emit_value = data_byte;
        final_done = frame_last;
      end
      default: begin
        phase_next = PH_SWALLOW;
        final_done = 1'b1;
      end
    endcase
  end

  assign end_valid = frame_last && !final_done;

  // both items carry the frame fields as they stand after this byte
  always_comb begin
    main_item.kind          = emit_kind;
    main_item.table_index   = emit_index;
    main_item.byte_value    = emit_value;
    main_item.frame_width   = width_reg_next;
    main_item.frame_height  = height_reg_next;
    main_item.frame_type    = baseline_flag_next;
    main_item.tables_seen   = tables_flag_next;
    main_item.restart_seen  = restart_flag_next;
    main_item.end_status    = emit_status;
    main_item.last_of_frame = emit_last;
    end_item                = main_item;
    end_item.kind           = KIND_END;
    end_item.table_index    = 6'd0;
    end_item.byte_value     = 8'd0;
    end_item.end_status     = 1'b1;
    end_item.last_of_frame  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SCAN;
      skip_count    <= 4'd0;
      entry_index   <= 6'd0;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      baseline_flag <= 1'b0;
      tables_flag   <= 1'b0;
      restart_flag  <= 1'b0;
      prev_was_ff   <= 1'b0;
    end else if (accept) begin
      if (frame_last) begin
        // frame state starts over for the next frame
        phase         <= PH_SCAN;
        skip_count    <= 4'd0;
        entry_index   <= 6'd0;
        width_reg     <= 16'd0;
        height_reg    <= 16'd0;
        baseline_flag <= 1'b0;
        tables_flag   <= 1'b0;
        restart_flag  <= 1'b0;
        prev_was_ff   <= 1'b0;
      end else begin
        phase         <= phase_next;
        skip_count    <= skip_count_next;
        entry_index   <= entry_index_next;
        width_reg     <= width_reg_next;
        height_reg    <= height_reg_next;
        baseline_flag <= baseline_flag_next;
        tables_flag   <= tables_flag_next;
        restart_flag  <= restart_flag_next;
        prev_was_ff   <= prev_was_ff_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (accept) begin
      out_valid  <= emit_valid || end_valid;
      pend_valid <= emit_valid && end_valid;
    end else if (pop) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item  <= emit_valid ? main_item : end_item;
      pend_item <= end_item;
    end else if (pop) begin
      out_item <= pend_item;
    end
  end

  assign kind          = out_item.kind;
  assign table_index   = out_item.table_index;
  assign byte_value    = out_item.byte_value;
  assign frame_width   = out_item.frame_width;
  assign frame_height  = out_item.frame_height;
  assign frame_type    = out_item.frame_type;
  assign quality       = out_item.tables_seen ? 8'hFF : 8'h00;
  assign restart_seen  = out_item.restart_seen;
  assign end_status    = out_item.end_status;
  assign last_of_frame = out_item.last_of_frame;

`ifndef SYNTHESIS
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("pending item without an item in the output register");

  a_pend_is_end: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (pend_item.kind == KIND_END && pend_item.last_of_frame))
    else $error("pending item is not a frame end item");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_last) |=> (phase == PH_SCAN && !prev_was_ff && !tables_flag))
    else $error("frame state not cleared after the last byte");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_last && !final_done) |=> (out_valid && out_item.last_of_frame == !pend_valid))
    else $error("frame end item not ordered last");
`endif

endmodule

/* bench/tb_jpeg_marker_header_parser_unit.sv */
// tb_jpeg_marker_header_parser_unit: self-checking bench for the jpeg marker parser
// drives frame bytes, predicts every result item and checks them in order
// depends on jmhp_pkg and jpeg_marker_header_parser_unit

module tb_jpeg_marker_header_parser_unit;
  import jmhp_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 25;
  localparam int SEND_GAP_PCT = 15;
  localparam int TABLE_LEN    = 64;
  localparam logic [7:0] QUALITY_TABLES = 8'd255;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  table_index;
    logic [7:0]  byte_value;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        frame_type;
    logic [7:0]  quality;
    logic        restart_seen;
    logic        end_status;
    logic        last_of_frame;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [5:0]  table_index;
  logic [7:0]  byte_value;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic        frame_type;
  logic [7:0]  quality;
  logic        restart_seen;
  logic        end_status;
  logic        last_of_frame;

  jpeg_marker_header_parser_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state as the bench sees it
  phase_t      parse_state;
  logic [3:0]  skip_left;
  logic [6:0]  entry_pos;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic        sof_seen;
  logic        dqt_seen;
  logic        dri_seen;
  logic        after_ff;

  result_t     expected_results[$];
  logic [7:0]  frame_q[$];
  result_t     got_result;
  result_t     want_result;

  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_count = 0;
  int          idle_cycles = 0;
  int          error_count = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          results_checked = 0;
  int          kind_count[5];

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic string describe(input result_t r);
    return $sformatf("kind=%0d idx=%0d val=%02h w=%04h h=%04h type=%0b q=%02h rst=%0b end=%0b last=%0b",
                     r.kind, r.table_index, r.byte_value, r.frame_width, r.frame_height,
                     r.frame_type, r.quality, r.restart_seen, r.end_status, r.last_of_frame);
  endfunction

  task automatic clear_frame_state();
    parse_state = PH_SCAN;
    skip_left = 4'd0;
    entry_pos = 7'd0;
    width_q = 16'd0;
    height_q = 16'd0;
    sof_seen = 1'b0;
    dqt_seen = 1'b0;
    dri_seen = 1'b0;
    after_ff = 1'b0;
  endtask

  task automatic push_result(input kind_t k, input logic [5:0] idx, input logic [7:0] val,
                             input logic est, input logic last);
    result_t r;
    r.kind = k;
    r.table_index = idx;
    r.byte_value = val;
    r.frame_width = width_q;
    r.frame_height = height_q;
    r.frame_type = sof_seen;
    r.quality = dqt_seen ? QUALITY_TABLES : 8'h00;
    r.restart_seen = dri_seen;
    r.end_status = est;
    r.last_of_frame = last;
    expected_results.push_back(r);
  endtask

  function automatic logic skip_finished();
    if (skip_left <= 4'd1) begin
      skip_left = 4'd0;
      return 1'b1;
    end
    skip_left = skip_left - 4'd1;
    return 1'b0;
  endfunction

  // works out the result items for one accepted frame byte
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic closed;
    logic run_over;
    closed = 1'b0;
    case (parse_state)
      PH_SCAN: begin
        if (after_ff && b >= MARKER_LOW && b <= MARKER_HIGH) begin
          after_ff = 1'b0;
          if (b == MARKER_DQT) begin
            dqt_seen = 1'b1;
            parse_state = PH_DQT_SKIP;
            skip_left = DQT_SKIP_LEN;
          end else if (b == MARKER_SOF0) begin
            sof_seen = 1'b1;
            parse_state = PH_SOF_SKIP;
            skip_left = SOF_SKIP_LEN;
          end else if (b == MARKER_DRI) begin
            dri_seen = 1'b1;
          end else if (b == MARKER_SOS) begin
            parse_state = PH_SOS_SKIP;
            skip_left = SOS_SKIP_LEN;
          end else if (b == MARKER_EOI) begin
            push_result(KIND_END, 6'd0, 8'h00, 1'b0, last);
            closed = 1'b1;
            parse_state = PH_SWALLOW;
          end
        end else begin
          after_ff = (b == BYTE_FF);
        end
      end
      PH_DQT_SKIP: begin
        if (skip_finished()) begin
          parse_state = PH_LUMA;
          entry_pos = 7'd0;
        end
      end
      PH_LUMA: begin
        push_result(KIND_LUMA, entry_pos[5:0], b, 1'b0, 1'b0);
        entry_pos = entry_pos + 7'd1;
        if (entry_pos >= TABLE_LEN) begin
          parse_state = PH_DQT_GAP;
          entry_pos = 7'd0;
        end
      end
      PH_DQT_GAP: begin
        parse_state = PH_CHROMA;
        entry_pos = 7'd0;
      end
      PH_CHROMA: begin
        push_result(KIND_CHROMA, entry_pos[5:0], b, 1'b0, 1'b0);
        entry_pos = entry_pos + 7'd1;
        if (entry_pos >= TABLE_LEN) begin
          parse_state = PH_SCAN;
          entry_pos = 7'd0;
        end
      end
      PH_SOF_SKIP: begin
        if (skip_finished()) parse_state = PH_H_HI;
      end
      PH_H_HI: begin
        height_q = {b, 8'h00};
        parse_state = PH_H_LO;
      end
      PH_H_LO: begin
        height_q = height_q | {8'h00, b};
        parse_state = PH_W_HI;
      end
      PH_W_HI: begin
        width_q = {b, 8'h00};
        parse_state = PH_W_LO;
      end
      PH_W_LO: begin
        width_q = width_q | {8'h00, b};
        parse_state = PH_SCAN;
      end
      PH_SOS_SKIP: begin
        // a frame cut short inside the skip still gets its header item
        run_over = skip_finished();
        if (run_over || last) begin
          push_result(KIND_HEADER, 6'd0, 8'h00, 1'b0, last);
          closed = last;
          parse_state = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        push_result(KIND_PAYLOAD, 6'd0, b, 1'b0, last);
        closed = last;
      end
      default: begin
        parse_state = PH_SWALLOW;
        closed = 1'b1;
      end
    endcase
    if (last) begin
      if (!closed) push_result(KIND_END, 6'd0, 8'h00, 1'b1, 1'b1);
      clear_frame_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady && $urandom_range(0, 99) < SEND_GAP_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    frame_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic add_marker(input logic [7:0] code);
    frame_q.push_back(BYTE_FF);
    frame_q.push_back(code);
  endtask

  task automatic add_random(input int n, input int ff_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < ff_pct) frame_q.push_back(BYTE_FF);
      else frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_dqt();
    add_marker(MARKER_DQT);
    add_random(3 + TABLE_LEN + 1 + TABLE_LEN, 10);
  endtask

  // mostly well-formed frames with random content, some cut off anywhere
  task automatic build_random_frame();
    int cut;
    frame_q.delete();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: begin
          if ($urandom_range(0, 1) == 0) add_dqt();
          else add_marker(8'($urandom_range(MARKER_LOW, MARKER_HIGH)));
        end
        1: begin
          add_marker(MARKER_SOF0);
          add_random(3, 10);
          repeat (4) begin
            case ($urandom_range(0, 3))
              0: frame_q.push_back(8'h00);
              1: frame_q.push_back(BYTE_FF);
              default: frame_q.push_back(8'($urandom_range(0, 255)));
            endcase
          end
        end
        2: begin
          add_marker(MARKER_DRI);
          add_random(4, 10);
        end
        3: begin
          add_marker(8'($urandom_range(MARKER_LOW, MARKER_HIGH)));
          add_random($urandom_range(0, 4), 10);
        end
        4: add_random($urandom_range(1, 6), 30);
        default: repeat ($urandom_range(1, 3)) frame_q.push_back(BYTE_FF);
      endcase
    end
    case ($urandom_range(0, 3))
      0, 1: begin
        add_marker(MARKER_SOS);
        add_random(SOS_SKIP_LEN, 10);
        add_random($urandom_range(0, 20), 15);
      end
      2: begin
        add_marker(MARKER_EOI);
        add_random($urandom_range(0, 3), 20);
      end
      default: add_random($urandom_range(0, 3), 10);
    endcase
    if (frame_q.size() > 1 && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  task automatic test_short_frames();
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{BYTE_FF, MARKER_EOI};
    send_frame();
    // last 0xff of a run counts, then bytes after the end marker are dropped
    frame_q = '{BYTE_FF, BYTE_FF, BYTE_FF, MARKER_EOI, 8'h55, BYTE_FF};
    send_frame();
    // frame runs out in the middle of the height
    frame_q = '{BYTE_FF, MARKER_DRI, BYTE_FF, MARKER_SOF0, 8'h00, 8'h11, 8'h08, BYTE_FF};
    send_frame();
    frame_q = '{BYTE_FF, MARKER_LOW - 8'd1, BYTE_FF, 8'h00, BYTE_FF, MARKER_HIGH, 8'h7F};
    send_frame();
    frame_q = '{BYTE_FF, MARKER_SOS, 8'h01, 8'h02, 8'h03};
    send_frame();
  endtask

  task automatic test_table_segments();
    frame_q.delete();
    add_marker(MARKER_SOF0);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h11);
    frame_q.push_back(8'h08);
    frame_q.push_back(BYTE_FF);
    frame_q.push_back(BYTE_FF);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    add_marker(MARKER_DQT);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h84);
    frame_q.push_back(8'h00);
    // an end marker inside the table is plain data
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i == 10) frame_q.push_back(BYTE_FF);
      else if (i == 11) frame_q.push_back(MARKER_EOI);
      else frame_q.push_back(8'(i * 4 + 3));
    end
    frame_q.push_back(8'h01);
    for (int i = 0; i < TABLE_LEN; i++) frame_q.push_back(8'(252 - i * 4));
    add_marker(MARKER_DRI);
    add_marker(MARKER_SOS);
    add_random(SOS_SKIP_LEN, 0);
    frame_q.push_back(8'h00);
    frame_q.push_back(BYTE_FF);
    frame_q.push_back(MARKER_EOI);
    frame_q.push_back(8'h80);
    send_frame();

    frame_q.delete();
    add_marker(MARKER_SOF0);
    add_random(3, 0);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    frame_q.push_back(BYTE_FF);
    frame_q.push_back(BYTE_FF);
    add_marker(MARKER_DQT);
    add_random(3, 0);
    for (int i = 0; i < TABLE_LEN; i++) frame_q.push_back(BYTE_FF);
    frame_q.push_back(BYTE_FF);
    for (int i = 0; i < TABLE_LEN; i++) frame_q.push_back(8'h00);
    add_marker(MARKER_EOI);
    frame_q.push_back(8'h12);
    frame_q.push_back(8'h34);
    send_frame();
  endtask

  task automatic test_well_formed_frames();
    int stop_at;
    int steady_until;
    stop_at = bytes_sent + 1000;
    steady_until = bytes_sent + 250;
    steady = 1'b1;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= steady_until) steady = 1'b0;
      build_random_frame();
      send_frame();
    end
    steady = 1'b0;
  endtask

  task automatic test_noise_frames();
    int stop_at;
    stop_at = bytes_sent + 250;
    while (bytes_sent < stop_at) begin
      frame_q.delete();
      repeat ($urandom_range(1, 24)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: frame_q.push_back(BYTE_FF);
          3: begin
            case ($urandom_range(0, 4))
              0: frame_q.push_back(MARKER_DQT);
              1: frame_q.push_back(MARKER_SOF0);
              2: frame_q.push_back(MARKER_DRI);
              3: frame_q.push_back(MARKER_SOS);
              default: frame_q.push_back(MARKER_EOI);
            endcase
          end
          4: frame_q.push_back(8'($urandom_range(MARKER_LOW, MARKER_HIGH)));
          default: frame_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      send_frame();
    end
  endtask

  // the receiver stops while a scan keeps streaming, so the input must stall
  task automatic test_output_hold_off();
    frame_q.delete();
    add_marker(MARKER_SOS);
    add_random(SOS_SKIP_LEN, 10);
    add_random(60, 15);
    hold_req = 1'b1;
    send_frame();
    hold_req = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_ready <= 1'b0;
    end else begin
      if (!hold_req) hold_count <= 0;
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_result = {kind, table_index, byte_value, frame_width, frame_height, frame_type,
                    quality, restart_seen, end_status, last_of_frame};
      results_checked++;
      if (kind <= KIND_END) kind_count[kind]++;
      if (expected_results.size() == 0) begin
        note_error({"unexpected result ", describe(got_result)});
      end else begin
        want_result = expected_results.pop_front();
        if (got_result !== want_result)
          note_error({"expected ", describe(want_result), " got ", describe(got_result)});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 5; i++) kind_count[i] = 0;
    clear_frame_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_frames();
    test_table_segments();
    test_well_formed_frames();
    test_noise_frames();
    test_output_hold_off();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d frames, %0d results checked: %0d luma, %0d chroma,",
             bytes_sent, frames_sent, results_checked, kind_count[KIND_LUMA],
             kind_count[KIND_CHROMA]);
    $display("%0d scan headers, %0d payload bytes, %0d frame ends, %0d errors",
             kind_count[KIND_HEADER], kind_count[KIND_PAYLOAD], kind_count[KIND_END],
             error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
